### hw/rtl/rcdc_pkg.sv
// ----------------------------------------------------------------------------
// rcdc_pkg: shared types and constants of the decimal-coded radix converter
// Field widths, error and register codes, the controller state type and the
// base clamp used by the datapath.
// ----------------------------------------------------------------------------
package rcdc_pkg;

  localparam int CODED_W    = 60;   // decimal-coded field width
  localparam int DIG_W      = 4;    // one decimal or base digit
  localparam int DEC_DIGITS = 19;   // decimal digits a 60-bit word can hold
  localparam int BASE_W     = 4;
  localparam int ERR_W      = 2;
  localparam int CNT_W      = $clog2(CODED_W);
  localparam int CFG_IDX_W  = 1;

  localparam logic [DIG_W-1:0]  DEC_ADJ_MIN = 4'd5;  // add-3 threshold
  localparam logic [DIG_W-1:0]  DEC_ADJ     = 4'd3;
  localparam logic [BASE_W-1:0] BASE_MIN    = 4'd2;
  localparam logic [BASE_W-1:0] BASE_MAX    = 4'd10;
  localparam logic [BASE_W-1:0] SRC_BASE_RST = 4'd10;
  localparam logic [BASE_W-1:0] TGT_BASE_RST = 4'd2;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DIGIT = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_BASE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_HORNER,
    ST_RADIX,
    ST_PACK
  } rcdc_state_t;

  // Saturate a base register into the supported range.
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    else if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

endpackage

### hw/rtl/radix_convert_decimal_coded.sv
// ----------------------------------------------------------------------------
// radix_convert_decimal_coded: decimal-coded radix converter
// Reads the decimal digits of in_coded_in as source-base digits, checks them,
// and returns the same value written in the target base, one decimal digit
// per target digit, with an error code.
// ----------------------------------------------------------------------------
// One item at a time. A beat is taken at a clock edge with start high and busy
// low; its result appears on out_coded_out and out_error_code for exactly one
// cycle, marked by out_valid, and must be taken then: there is no back-pressure.
// A good conversion runs from the accepting edge through a bit-serial
// binary-to-decimal split, Horner accumulation in the source base (one digit a
// cycle through a 60x4 multiplier), shifting the value bit by bit into a
// base-digit register, packing those digits back into a binary word, and the
// strobe cycle itself. A bad source digit ends the item in the Horner step (the
// topmost of the 19 decimal digits is never above one, so it always passes); a
// result wider than MAX_DIGITS digits ends it at the first packing step.
// busy drops in the strobe cycle, so the next beat can be taken alongside it.
// Write cfg_* only while busy is low. Base registers outside 2..10 saturate.
// ----------------------------------------------------------------------------
module radix_convert_decimal_coded
  import rcdc_pkg::*;
#(
  parameter int MAX_DIGITS = 18   // capacity of the result, 1..18 digits
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BASE_W-1:0]    cfg_wdata,
  // input beat
  input  logic                 start,
  output logic                 busy,
  input  logic [CODED_W-1:0]   in_coded_in,
  // result beat
  output logic                 out_valid,
  output logic [CODED_W-1:0]   out_coded_out,
  output logic [ERR_W-1:0]     out_error_code
);

  localparam int DEC_W = DEC_DIGITS * DIG_W;
  localparam int TD_W  = MAX_DIGITS * DIG_W;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  rcdc_state_t         state_r, state_nxt;
  logic [BASE_W-1:0]   src_base_r, tgt_base_r;
  logic [CODED_W-1:0]  acc_r, acc_nxt;     // input, then value, then result
  logic [DEC_W-1:0]    bcd_r, bcd_nxt;     // decimal digits of the input
  logic [TD_W-1:0]     tdig_r, tdig_nxt;   // target-base digits
  logic                ovf_r, ovf_nxt;     // target digits ran past capacity
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CODED_W-1:0]  out_coded_out_r, out_coded_out_nxt;
  logic [ERR_W-1:0]    out_error_code_r, out_error_code_nxt;

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic [BASE_W-1:0]          src_base, tgt_base;
  logic                       accept;
  logic                       last_step;
  logic [DIG_W-1:0]           src_digit;
  logic                       digit_bad;
  logic [DEC_W-1:0]           bcd_adj;
  logic [CODED_W+BASE_W-1:0]  horner_prod;
  logic [CODED_W-1:0]         horner_sum;
  logic [MAX_DIGITS-1:0]      td_gen, td_prop, td_cin;
  logic [MAX_DIGITS:0]        td_sum;
  logic [TD_W-1:0]            tdig_dbl;
  logic [DIG_W-1:0]           tgt_top;
  logic [CODED_W-1:0]         pack_sum;

  assign src_base  = clamp_base(src_base_r);
  assign tgt_base  = clamp_base(tgt_base_r);
  assign accept    = start && (state_r == ST_IDLE);
  assign last_step = (cnt_r == '0);

  // Binary to decimal: add three to every digit of five or more, then shift.
  always_comb begin
    logic [DIG_W-1:0] d;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      d = bcd_r[i*DIG_W +: DIG_W];
      bcd_adj[i*DIG_W +: DIG_W] = (d >= DEC_ADJ_MIN) ? d + DEC_ADJ : d;
    end
  end

  // Horner step on the most significant remaining decimal digit.
  assign src_digit   = bcd_r[DEC_W-1 -: DIG_W];
  assign digit_bad   = (src_digit >= src_base);
  assign horner_prod = {{BASE_W{1'b0}}, acc_r} * {{CODED_W{1'b0}}, src_base};
  assign horner_sum  = horner_prod[CODED_W-1:0]
                     + {{(CODED_W-DIG_W){1'b0}}, src_digit};

  // Double the target-base digit register and add the next value bit.
  // A digit generates a carry when 2d reaches the base, and passes one on
  // when only 2d+1 does; the carries then resolve as one binary add.
  always_comb begin
    logic [DIG_W:0] two_d;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      two_d      = {tdig_r[i*DIG_W +: DIG_W], 1'b0};
      td_gen[i]  = (two_d >= {1'b0, tgt_base});
      td_prop[i] = !td_gen[i] && ((two_d | 5'd1) >= {1'b0, tgt_base});
    end
  end

  assign td_sum = {1'b0, td_gen | td_prop} + {1'b0, td_gen}
                + {{MAX_DIGITS{1'b0}}, acc_r[CODED_W-1]};

  always_comb begin
    logic [DIG_W:0] raw;
    logic           cout;
    td_cin = td_sum[MAX_DIGITS-1:0] ^ (td_gen | td_prop) ^ td_gen;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      raw  = {tdig_r[i*DIG_W +: DIG_W], td_cin[i]};
      cout = td_gen[i] | (td_prop[i] & td_cin[i]);
      raw  = cout ? raw - {1'b0, tgt_base} : raw;
      tdig_dbl[i*DIG_W +: DIG_W] = raw[DIG_W-1:0];
    end
  end

  // Pack: result = result * 10 + next target digit, most significant first.
  assign tgt_top  = tdig_r[TD_W-1 -: DIG_W];
  assign pack_sum = (acc_r << 3) + (acc_r << 1)
                  + {{(CODED_W-DIG_W){1'b0}}, tgt_top};

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DABBLE;
      end
      ST_DABBLE: begin
        if (last_step) state_nxt = ST_HORNER;
      end
      ST_HORNER: begin
        if (digit_bad) state_nxt = ST_IDLE;
        else if (last_step) state_nxt = ST_RADIX;
      end
      ST_RADIX: begin
        if (last_step) state_nxt = ST_PACK;
      end
      ST_PACK: begin
        if (ovf_r || last_step) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    acc_nxt            = acc_r;
    bcd_nxt            = bcd_r;
    tdig_nxt           = tdig_r;
    ovf_nxt            = ovf_r;
    cnt_nxt            = cnt_r - 1'b1;
    out_valid_nxt      = 1'b0;
    out_coded_out_nxt  = out_coded_out_r;
    out_error_code_nxt = out_error_code_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = cnt_r;
        if (start) begin
          // load the beat and start the decimal split
          acc_nxt = in_coded_in;
          bcd_nxt = '0;
          cnt_nxt = CNT_W'(CODED_W - 1);
        end
      end
      ST_DABBLE: begin
        bcd_nxt = {bcd_adj[DEC_W-2:0], acc_r[CODED_W-1]};
        acc_nxt = acc_r << 1;
        if (last_step) begin
          acc_nxt = '0;
          cnt_nxt = CNT_W'(DEC_DIGITS - 1);
        end
      end
      ST_HORNER: begin
        if (digit_bad) begin
          // drop the item: a digit is not below the source base
          out_valid_nxt      = 1'b1;
          out_coded_out_nxt  = '0;
          out_error_code_nxt = ERR_DIGIT;
        end else begin
          acc_nxt = horner_sum;
          bcd_nxt = bcd_r << DIG_W;
          if (last_step) begin
            tdig_nxt = '0;
            ovf_nxt  = 1'b0;
            cnt_nxt  = CNT_W'(CODED_W - 1);
          end
        end
      end
      ST_RADIX: begin
        tdig_nxt = tdig_dbl;
        ovf_nxt  = ovf_r | td_sum[MAX_DIGITS];
        acc_nxt  = acc_r << 1;
        if (last_step) cnt_nxt = CNT_W'(MAX_DIGITS - 1);
      end
      ST_PACK: begin
        if (ovf_r) begin
          out_valid_nxt      = 1'b1;
          out_coded_out_nxt  = '0;
          out_error_code_nxt = ERR_RANGE;
        end else begin
          acc_nxt  = pack_sum;
          tdig_nxt = tdig_r << DIG_W;
          if (last_step) begin
            out_valid_nxt      = 1'b1;
            out_coded_out_nxt  = pack_sum;
            out_error_code_nxt = ERR_NONE;
          end
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  always_comb begin
    busy           = (state_r != ST_IDLE);
    out_valid      = out_valid_r;
    out_coded_out  = out_coded_out_r;
    out_error_code = out_error_code_r;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      src_base_r  <= SRC_BASE_RST;
      tgt_base_r  <= TGT_BASE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_SRC_BASE) src_base_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_TGT_BASE) tgt_base_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    acc_r            <= acc_nxt;
    bcd_r            <= bcd_nxt;
    tdig_r           <= tdig_nxt;
    ovf_r            <= ovf_nxt;
    cnt_r            <= cnt_nxt;
    out_coded_out_r  <= out_coded_out_nxt;
    out_error_code_r <= out_error_code_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while the converter is still working");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted beat did not start a conversion");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_code_r != ERR_NONE) |-> (out_coded_out_r == '0))
    else $error("error result carries a non-zero value");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("two result strobes in a row");

endmodule

### tb/radix_convert_decimal_coded_tb.sv
// ----------------------------------------------------------------------------
// radix_convert_decimal_coded_tb: self-checking bench for the radix converter
// Drives decimal-coded numbers through the start/busy port under a range of
// base settings and sender gaps, predicts every conversion and error code
// in-bench, and compares each strobed result beat against the oldest pending
// prediction.
// ----------------------------------------------------------------------------
module radix_convert_decimal_coded_tb
  import rcdc_pkg::*;
;

  localparam int RESULT_DIGITS   = 18;   // digit capacity given to the block
  localparam int ITEMS_PER_PHASE = 250;  // random beats per traffic phase
  localparam int DRAIN_CYCLES    = 200;  // above the longest conversion

  typedef struct packed {
    logic [CODED_W-1:0] coded;
    logic [ERR_W-1:0]   err;
  } conversion_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BASE_W-1:0]    cfg_wdata;
  logic                 start;
  logic                 busy;
  logic [CODED_W-1:0]   in_coded_in;
  logic                 out_valid;
  logic [CODED_W-1:0]   out_coded_out;
  logic [ERR_W-1:0]     out_error_code;

  // Bench copy of the two base registers, raw as written.
  logic [BASE_W-1:0] model_src_radix;
  logic [BASE_W-1:0] model_tgt_radix;

  // Predicted result beats, oldest first.
  conversion_t awaited_results[$];
  int          mismatches;
  int          sender_idle_pct;

  radix_convert_decimal_coded #(
    .MAX_DIGITS(RESULT_DIGITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .in_coded_in   (in_coded_in),
    .out_valid     (out_valid),
    .out_coded_out (out_coded_out),
    .out_error_code(out_error_code)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Saturate a raw register value into the working range 2..10.
  function automatic int radix_of(input logic [BASE_W-1:0] r);
    if (r < 2) return 2;
    if (r > 10) return 10;
    return int'(r);
  endfunction

  // Predict one conversion: split into decimal digits, check each against the
  // source base, accumulate Horner-style, then re-split in the target base.
  function automatic conversion_t convert_coded(input logic [CODED_W-1:0] coded,
                                                input logic [BASE_W-1:0] src_reg,
                                                input logic [BASE_W-1:0] tgt_reg);
    longint unsigned rest;
    longint unsigned value;
    longint unsigned packed_res;
    logic [3:0]      digs [0:63];
    int              n;
    int              sb;
    int              tb;
    conversion_t     r;
    sb = radix_of(src_reg);
    tb = radix_of(tgt_reg);
    r.coded = '0;
    rest = coded;
    n = 0;
    while (rest != 0) begin
      digs[n] = 4'(rest % 10);
      rest = rest / 10;
      n++;
    end
    // a bad digit wins over any capacity problem
    for (int i = 0; i < n; i++) begin
      if (digs[i] >= sb) begin
        r.err = ERR_DIGIT;
        return r;
      end
    end
    value = 0;
    for (int i = n - 1; i >= 0; i--) value = value * sb + digs[i];
    n = 0;
    while (value != 0) begin
      digs[n] = 4'(value % tb);
      value = value / tb;
      n++;
    end
    if (n > RESULT_DIGITS) begin
      r.err = ERR_RANGE;
      return r;
    end
    packed_res = 0;
    for (int i = n - 1; i >= 0; i--) packed_res = packed_res * 10 + digs[i];
    r.coded = packed_res[CODED_W-1:0];
    r.err   = ERR_NONE;
    return r;
  endfunction

  // Build a decimal-coded number of ndig base digits; optionally plant one
  // digit that is not below the base.
  function automatic logic [CODED_W-1:0] digit_string(input int base, input int ndig,
                                                      input bit corrupt);
    longint unsigned acc;
    int              bad;
    int              d;
    acc = 0;
    bad = (corrupt && base < 10) ? int'($urandom_range(0, ndig - 1)) : -1;
    for (int k = 0; k < ndig; k++) begin
      d = (k == bad) ? int'($urandom_range(base, 9)) : int'($urandom_range(0, base - 1));
      acc = acc * 10 + d;
    end
    return acc[CODED_W-1:0];
  endfunction

  // Mostly in-range bases, now and then a raw register value to hit saturation.
  function automatic logic [BASE_W-1:0] pick_radix();
    if ($urandom_range(0, 4) == 0) return BASE_W'($urandom_range(0, 15));
    return BASE_W'($urandom_range(2, 10));
  endfunction

  // Result checker: every strobe must match the oldest prediction.
  always @(posedge clk) begin
    conversion_t want;
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing pending: coded_out=%0d error_code=%0d",
               out_coded_out, out_error_code);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_coded_out !== want.coded) begin
          $error("coded_out mismatch: expected %0d, got %0d", want.coded, out_coded_out);
          mismatches++;
        end
        if (out_error_code !== want.err) begin
          $error("error_code mismatch: expected %0d, got %0d", want.err, out_error_code);
          mismatches++;
        end
      end
    end
  end

  // Present one beat, idling first at the current rate, and hold it until the
  // block takes it. Leave start high so back-to-back beats need no toggle.
  task automatic send_coded(input logic [CODED_W-1:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    // stretch the odd gap so pauses land across every stage of a conversion
    if (gap != 0 && $urandom_range(0, 7) == 0) gap += $urandom_range(0, 170);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_coded_in <= value;
    do @(posedge clk); while (busy !== 1'b0);
    awaited_results.push_back(convert_coded(value, model_src_radix, model_tgt_radix));
  endtask

  // Drop start and hold off until every pending result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_radix(input logic [CFG_IDX_W-1:0] idx,
                             input logic [BASE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SRC_BASE) model_src_radix = value;
    else model_tgt_radix = value;
    @(posedge clk);
  endtask

  // Reprogram both bases with the block idle.
  task automatic set_radices(input logic [BASE_W-1:0] src, input logic [BASE_W-1:0] tgt);
    drain_results();
    write_radix(CFG_SRC_BASE, src);
    write_radix(CFG_TGT_BASE, tgt);
  endtask

  // Out of reset the block converts decimal to binary.
  task automatic test_reset_defaults();
    send_coded(60'd0);
    send_coded(60'd5);
    send_coded(60'd262143);   // eighteen binary ones, just fits
    send_coded(60'd262144);   // needs nineteen binary digits
  endtask

  // Widest inputs and identity conversions.
  task automatic test_field_extremes();
    set_radices(4'd10, 4'd10);
    send_coded(60'd0);
    send_coded(60'd1152921504606846975);   // every input bit set, nineteen digits
    send_coded(60'd999999999999999999);
    send_coded(60'd1000000000000000000);   // nineteen decimal digits out
    set_radices(4'd9, 4'd9);
    send_coded(60'd888888888888888888);
    set_radices(4'd2, 4'd10);
    send_coded(60'd111111111111111111);
  endtask

  // Register values outside 2..10 must saturate.
  task automatic test_base_saturation();
    set_radices(4'd0, 4'd15);
    send_coded(60'd101);
    send_coded(60'd2);
    set_radices(4'd11, 4'd1);
    send_coded(60'd3);
    send_coded(60'd1000000);
    set_radices(4'd1, 4'd11);
    send_coded(60'd11);
  endtask

  // Digit errors, capacity errors and their priority.
  task automatic test_error_cases();
    set_radices(4'd2, 4'd2);
    send_coded(60'd1152921504606846975);   // bad digits and far too wide
    send_coded(60'd1111111111111111111);   // nineteen source digits, too wide out
    set_radices(4'd10, 4'd3);
    send_coded(60'd387420489);             // three to the eighteenth
    send_coded(60'd387420488);
    set_radices(4'd8, 4'd10);
    send_coded(60'd9);
    send_coded(60'd777);
  endtask

  // Random traffic under one base setting and one sender idle rate.
  task automatic test_random_traffic(input int idle_pct, input logic [BASE_W-1:0] src,
                                     input logic [BASE_W-1:0] tgt);
    int unsigned        pick;
    logic [CODED_W-1:0] value;
    set_radices(src, tgt);
    sender_idle_pct = idle_pct;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      // halfway through, hold off until the block has emptied
      if (n == ITEMS_PER_PHASE / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 70) value = digit_string(radix_of(src), $urandom_range(1, 18), 1'b0);
      else if (pick < 85) value = digit_string(radix_of(src), $urandom_range(1, 18), 1'b1);
      else if (pick < 95) value = CODED_W'({$urandom, $urandom});
      else value = CODED_W'($urandom_range(0, 9));
      send_coded(value);
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_coded_in <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    mismatches      = 0;
    sender_idle_pct = 0;
    model_src_radix = SRC_BASE_RST;
    model_tgt_radix = TGT_BASE_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_base_saturation();
    test_error_cases();

    // extremes first, then random settings; rates cycle through none/54/33
    test_random_traffic(0, 4'd2, 4'd10);
    test_random_traffic(54, 4'd10, 4'd2);
    test_random_traffic(33, 4'd10, 4'd10);
    test_random_traffic(0, pick_radix(), pick_radix());
    test_random_traffic(54, pick_radix(), pick_radix());
    test_random_traffic(33, pick_radix(), pick_radix());
    test_random_traffic(0, pick_radix(), pick_radix());

    // wait out the last results, then watch for any stray strobe
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #30000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
